>>> sv/grouped_median_age_select_defines.svh
// assertion macros for the grouped median age selector
// no dependencies
`ifndef GROUPED_MEDIAN_AGE_SELECT_DEFINES_SVH
`define GROUPED_MEDIAN_AGE_SELECT_DEFINES_SVH
// implication checked at every clock while out of reset
`define GMAS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("check failed");
// next-cycle implication
`define GMAS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("check failed");
`endif

>>> sv/gmas_pkg.sv
// shared types and constants of the grouped median age selector
// no dependencies
package gmas_pkg;
    localparam int AGE_W   = 7;
    localparam int REC_W   = 9;
    localparam int GROUP_W = 3;
    localparam int NUM_GROUPS = 7;
    localparam logic [GROUP_W-1:0] GRP_ALL  = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_LAST = 3'd6;

    typedef enum logic [1:0] {
        t_ST_LOAD,
        t_ST_SCAN,
        t_ST_EMIT
    } t_state;

    // one queue entry: a record and its end-of-set mark
    typedef struct packed {
        logic [REC_W-1:0] rec;
        logic             last;
    } t_qent;

    function automatic logic in_group(input logic [GROUP_W-1:0] g,
                                      input logic [REC_W-1:0] rec);
        logic male;
        logic emp;
        male = rec[7];
        emp  = rec[8];
        case (g)
            3'd0:    in_group = 1'b1;
            3'd1:    in_group = !male;
            3'd2:    in_group = male;
            3'd3:    in_group = !male && emp;
            3'd4:    in_group = !male && !emp;
            3'd5:    in_group = male && emp;
            default: in_group = male && !emp;
        endcase
    endfunction
endpackage

>>> sv/gmas_front.sv
// front: accepts records into a two-entry queue
// depends on gmas_pkg
module gmas_front import gmas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [AGE_W-1:0] i_age,
    input  logic             i_is_male,
    input  logic             i_employed,
    input  logic             i_last_person,
    output logic             o_q_valid,
    output t_qent            o_q_data,
    input  logic             i_q_ready
);
    t_qent      r_q [2];
    logic [0:0] r_rd;
    logic [0:0] r_wr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr].rec  <= {i_employed, i_is_male, i_age};
            r_q[r_wr].last <= i_last_person;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> sv/gmas_back.sv
// back: stores records, counts group records at or below each age level by scanning, emits medians
// depends on gmas_pkg and the defines header
`include "grouped_median_age_select_defines.svh"
module gmas_back import gmas_pkg::*; #(
    parameter int MAX_PERSONS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_qent              i_q_data,
    output logic               o_q_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [GROUP_W-1:0] o_group,
    output logic [AGE_W-1:0]   o_median_age,
    output logic               o_last_result
);
    localparam int AW = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
    localparam int CW = $clog2(MAX_PERSONS + 1);

    logic [REC_W-1:0] r_mem [MAX_PERSONS];
    logic [REC_W-1:0] r_rdata;
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [GROUP_W-1:0] r_group;
    logic [AGE_W-1:0] r_age;      // age level under test
    logic [CW-1:0]    r_idx;      // read address issued
    logic             r_rd_v;     // r_rdata valid for this pass
    logic [CW-1:0]    r_n;        // group size
    logic [CW-1:0]    r_le;       // group records with age <= r_age
    logic             r_first;    // first pass counts group size
    logic             r_found;
    logic [AGE_W-1:0] r_med;
    logic             r_out_v;

    logic w_pop, w_pass_end, w_hit;
    logic [CW-1:0] w_le_next;

    assign o_q_ready = (r_state == t_ST_LOAD) && !r_out_v;
    assign w_pop     = i_q_valid && o_q_ready;
    assign w_hit     = r_rd_v && in_group(r_group, r_rdata);
    assign w_pass_end = (r_idx == r_count) && !r_rd_v;
    assign w_le_next = r_le + {{(CW-1){1'b0}},
                       (w_hit && (r_rdata[AGE_W-1:0] <= r_age))};

    always_ff @(posedge i_clk) begin
        if (w_pop && (r_count != CW'(MAX_PERSONS)))
            r_mem[r_count[AW-1:0]] <= i_q_data.rec;
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_LOAD: if (w_pop && i_q_data.last) n_state = t_ST_SCAN;
            t_ST_SCAN: if (r_found || (w_pass_end && !r_first &&
                           (r_n == '0 || r_age == '1))) n_state = t_ST_EMIT;
            t_ST_EMIT: if (!r_out_v) n_state = (r_group == GRP_LAST) ? t_ST_LOAD : t_ST_SCAN;
            default:   n_state = t_ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_LOAD;
            r_count <= '0;
            r_group <= GRP_ALL;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_first <= 1'b1;
            r_found <= 1'b0;
            r_age   <= '0;
            r_n     <= '0;
            r_le    <= '0;
            r_med   <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            unique case (r_state)
                t_ST_LOAD: begin
                    if (w_pop && (r_count != CW'(MAX_PERSONS)))
                        r_count <= r_count + 1'b1;
                    r_group <= GRP_ALL;
                    r_idx <= '0; r_rd_v <= 1'b0; r_first <= 1'b1;
                    r_found <= 1'b0; r_age <= '0; r_n <= '0; r_le <= '0;
                end
                t_ST_SCAN: begin
                    // stream records once per pass; one age level per pass
                    if (r_idx != r_count) begin
                        r_idx  <= r_idx + 1'b1;
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_first) begin
                        if (w_hit) r_n <= r_n + 1'b1;
                    end else begin
                        r_le <= w_le_next;
                    end
                    if (w_pass_end) begin
                        r_idx <= '0;
                        r_le  <= '0;
                        if (r_first) begin
                            r_first <= 1'b0;
                            r_med   <= '0;
                            if (r_n == '0) r_found <= 1'b1;
                        end else if (r_le > (r_n >> 1)) begin
                            r_found <= 1'b1;
                            r_med   <= r_age;
                        end else begin
                            r_age <= r_age + 1'b1;
                        end
                    end
                    if (n_state == t_ST_EMIT) r_out_v <= 1'b1;
                end
                t_ST_EMIT: begin
                    if (!r_out_v) begin
                        if (r_group == GRP_LAST) r_count <= '0;
                        r_group <= r_group + 1'b1;
                        r_idx <= '0; r_rd_v <= 1'b0; r_first <= 1'b1;
                        r_found <= 1'b0; r_age <= '0; r_n <= '0; r_le <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_out_v && (r_state == t_ST_EMIT);
    assign o_group       = r_group;
    assign o_median_age  = r_med;
    assign o_last_result = (r_group == GRP_LAST);

    `GMAS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_PERSONS))
    `GMAS_ASSERT_IMP(a_no_load_busy, i_clk, i_rst_n, r_state != t_ST_LOAD, !o_q_ready)
    `GMAS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n,
        o_valid && i_ready && o_last_result, r_count == '0 || r_state == t_ST_EMIT)
endmodule

>>> sv/grouped_median_age_select.sv
// grouped median age selector: records load at one per cycle through a two-entry queue
// when not stalled; after the last record each group is scanned once for its size,
// then once per age level up to its median age; an empty group gets only the size scan
// the selection stalls record intake until the seventh median transfer
// synchronous active-low reset clears counts and control; memory is not cleared
// depends on gmas_pkg, gmas_front, gmas_back
module grouped_median_age_select import gmas_pkg::*; #(
    parameter int MAX_PERSONS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [AGE_W-1:0]   i_age,
    input  logic               i_is_male,
    input  logic               i_employed,
    input  logic               i_last_person,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [GROUP_W-1:0] o_group,
    output logic [AGE_W-1:0]   o_median_age,
    output logic               o_last_result
);
    // queue between record intake and the selection engine
    logic  w_q_valid;
    t_qent w_q_data;
    logic  w_q_ready;

    gmas_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_age, .i_is_male,
        .i_employed, .i_last_person,
        .o_q_valid (w_q_valid), .o_q_data (w_q_data), .i_q_ready (w_q_ready)
    );

    // store, scan and output register
    gmas_back #(.MAX_PERSONS(MAX_PERSONS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid (w_q_valid), .i_q_data (w_q_data), .o_q_ready (w_q_ready),
        .o_valid, .i_ready, .o_group, .o_median_age, .o_last_result
    );
endmodule
